@@ rtl/core/tzx_tape_block_deframer_unit_macros.svh @@
// assertion helpers for the tzx deframer checker
// both sample on the rising edge of clk and stay quiet while rst_n is low
`ifndef TZX_TAPE_BLOCK_DEFRAMER_UNIT_MACROS_SVH
`define TZX_TAPE_BLOCK_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define TZXDF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TZXDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tzxdf_pkg.sv @@
`timescale 1ns / 1ps
package tzxdf_pkg;

  // request kinds on the input channel
  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_REWIND = 1'b1;

  // result kinds
  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_START   = 2'd1,
    EV_BAD_SIG = 2'd2,
    EV_BAD_ID  = 2'd3
  } event_t;

  // block ids handled
  localparam logic [7:0] ID_STD_DATA = 8'h10;
  localparam logic [7:0] ID_TEXT     = 8'h30;
  localparam logic [7:0] ID_ARCHIVE  = 8'h32;
  localparam logic [7:0] ID_HW_INFO  = 8'h33;

  localparam logic [2:0] SIG_LAST_IDX = 3'd6;

  // pause conversion: ms / 20 = (ms >> 2) / 5, capped at 100 frames
  localparam logic [15:0] PAUSE_CAP_MS = 16'd2020;
  localparam logic [6:0]  FRAMES_MAX   = 7'd100;
  localparam logic [15:0] RECIP_5      = 16'd52429;
  localparam int          RECIP_SHIFT  = 18;

  // parser phases, one-hot
  typedef enum logic [19:0] {
    PH_SIG      = 20'h00001,
    PH_MARK     = 20'h00002,
    PH_VMAJ     = 20'h00004,
    PH_VMIN     = 20'h00008,
    PH_ID       = 20'h00010,
    PH_P_LO     = 20'h00020,
    PH_P_HI     = 20'h00040,
    PH_L_LO     = 20'h00080,
    PH_L_HI     = 20'h00100,
    PH_DATA     = 20'h00200,
    PH_TXT_LEN  = 20'h00400,
    PH_SKIP     = 20'h00800,
    PH_ARC_LO   = 20'h01000,
    PH_ARC_HI   = 20'h02000,
    PH_ARC_N    = 20'h04000,
    PH_STR_TYPE = 20'h08000,
    PH_STR_LEN  = 20'h10000,
    PH_STR_SKIP = 20'h20000,
    PH_HW_N     = 20'h40000,
    PH_STOP     = 20'h80000
  } phase_t;

  // one classified result between front and back
  typedef struct packed {
    event_t      ev;
    logic [7:0]  data;
    logic [15:0] len;
    logic [15:0] pause_ms;
    logic        last;
  } res_t;

  // "ZXTape!" signature bytes
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h5A;
      3'd1:    val = 8'h58;
      3'd2:    val = 8'h54;
      3'd3:    val = 8'h61;
      3'd4:    val = 8'h70;
      3'd5:    val = 8'h65;
      3'd6:    val = 8'h21;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/tzx_tape_block_deframer_unit.sv @@
// result path: the result of an accepted byte is registered first in the result queue,
//   then in the output register, from which it is taken on the output
// throughput: one request per cycle; up to three results (two queued, one in the output
//   register) wait while out_tready is low, after that in_tready drops for every request
// reset: rst_n synchronous active low; parser restarts at the signature,
//   suppress_pause clears, queue and output register empty
`timescale 1ns / 1ps
module tzx_tape_block_deframer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // suppress_pause
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // tape_byte
  input  logic        in_tuser,       // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // data_byte, block_length, pause_frames, zero pad
  output logic [1:0]  out_tuser,      // event_res
  output logic        out_tlast       // last_in_block
);
  import tzxdf_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  res_t push_data, pop_data;

  // parser and classifier
  tzxdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_tvalid),
    .in_cmd     (in_tuser),
    .in_byte    (in_tdata),
    .push_ready (push_ready),
    .in_ready   (in_tready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // result queue
  tzxdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // pause conversion and output register
  tzxdf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

@@ rtl/core/tzxdf_front.sv @@
`timescale 1ns / 1ps
module tzxdf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  input  logic               in_cmd,
  input  logic [7:0]         in_byte,
  input  logic               push_ready,
  output logic               in_ready,
  output logic               push_valid,
  output tzxdf_pkg::res_t    push_data
);
  import tzxdf_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] pause_r, pause_nxt;
  logic [7:0]  strings_r, strings_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        suppress_r;
  logic        accept;
  logic        res_vld;
  res_t        res;
  logic [9:0]  hw_len;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;
  assign hw_len   = {2'b00, in_byte} + {1'b0, in_byte, 1'b0};

  // grammar walk for one byte
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    pause_nxt   = pause_r;
    strings_nxt = strings_r;
    low_nxt     = low_r;
    res_vld     = 1'b0;
    res         = '{ev: EV_PAYLOAD, data: 8'h00, len: 16'h0000,
                    pause_ms: 16'h0000, last: 1'b0};
    unique case (phase_r)
      PH_SIG: begin
        if (in_byte != sig_byte(cnt_r[2:0])) begin
          phase_nxt = PH_STOP;
          res_vld   = 1'b1;
          res.ev    = EV_BAD_SIG;
          res.data  = in_byte;
        end else if (cnt_r[2:0] == SIG_LAST_IDX) begin
          cnt_nxt   = '0;
          phase_nxt = PH_MARK;
        end else begin
          cnt_nxt = cnt_r + 16'd1;
        end
      end
      PH_MARK: phase_nxt = PH_VMAJ;
      PH_VMAJ: phase_nxt = PH_VMIN;
      PH_VMIN: phase_nxt = PH_ID;
      PH_ID: begin
        if (in_byte == ID_STD_DATA) begin
          phase_nxt = PH_P_LO;
        end else if (in_byte == ID_TEXT) begin
          phase_nxt = PH_TXT_LEN;
        end else if (in_byte == ID_ARCHIVE) begin
          phase_nxt = PH_ARC_LO;
        end else if (in_byte == ID_HW_INFO) begin
          phase_nxt = PH_HW_N;
        end else begin
          phase_nxt = PH_STOP;
          res_vld   = 1'b1;
          res.ev    = EV_BAD_ID;
          res.data  = in_byte;
        end
      end
      PH_P_LO: begin
        low_nxt   = in_byte;
        phase_nxt = PH_P_HI;
      end
      PH_P_HI: begin
        pause_nxt = suppress_r ? 16'h0000 : {in_byte, low_r};
        phase_nxt = PH_L_LO;
      end
      PH_L_LO: begin
        low_nxt   = in_byte;
        phase_nxt = PH_L_HI;
      end
      PH_L_HI: begin
        cnt_nxt      = {in_byte, low_r};
        phase_nxt    = ({in_byte, low_r} == 16'h0000) ? PH_ID : PH_DATA;
        res_vld      = 1'b1;
        res.ev       = EV_START;
        res.len      = {in_byte, low_r};
        res.pause_ms = pause_r;
      end
      PH_DATA: begin
        cnt_nxt      = cnt_r - 16'd1;
        res_vld      = 1'b1;
        res.ev       = EV_PAYLOAD;
        res.data     = in_byte;
        res.pause_ms = pause_r;
        res.last     = (cnt_r == 16'd1);
        if (cnt_r == 16'd1) begin
          phase_nxt = PH_ID;
        end
      end
      PH_TXT_LEN: begin
        cnt_nxt   = {8'h00, in_byte};
        phase_nxt = (in_byte == 8'h00) ? PH_ID : PH_SKIP;
      end
      PH_SKIP: begin
        cnt_nxt = cnt_r - 16'd1;
        if (cnt_r == 16'd1) begin
          phase_nxt = PH_ID;
        end
      end
      PH_ARC_LO: phase_nxt = PH_ARC_HI;
      PH_ARC_HI: phase_nxt = PH_ARC_N;
      PH_ARC_N: begin
        strings_nxt = in_byte;
        phase_nxt   = (in_byte != 8'h00) ? PH_STR_TYPE : PH_ID;
      end
      PH_STR_TYPE: phase_nxt = PH_STR_LEN;
      PH_STR_LEN: begin
        strings_nxt = strings_r - 8'd1;
        cnt_nxt     = {8'h00, in_byte};
        if (in_byte != 8'h00) begin
          phase_nxt = PH_STR_SKIP;
        end else begin
          phase_nxt = (strings_r != 8'd1) ? PH_STR_TYPE : PH_ID;
        end
      end
      PH_STR_SKIP: begin
        cnt_nxt = cnt_r - 16'd1;
        if (cnt_r == 16'd1) begin
          phase_nxt = (strings_r != 8'h00) ? PH_STR_TYPE : PH_ID;
        end
      end
      PH_HW_N: begin
        cnt_nxt   = {6'b000000, hw_len};
        phase_nxt = (in_byte == 8'h00) ? PH_ID : PH_SKIP;
      end
      PH_STOP: phase_nxt = PH_STOP;
      default: phase_nxt = PH_STOP;
    endcase
  end

  assign push_valid = accept & (in_cmd == CMD_BYTE) & res_vld;
  assign push_data  = res;

  // parser state, rewind restarts at the signature
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIG;
      cnt_r      <= '0;
      pause_r    <= '0;
      strings_r  <= '0;
      low_r      <= '0;
      suppress_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        suppress_r <= cfg_wdata;
      end
      if (accept) begin
        if (in_cmd == CMD_REWIND) begin
          phase_r   <= PH_SIG;
          cnt_r     <= '0;
          pause_r   <= '0;
          strings_r <= '0;
          low_r     <= '0;
        end else begin
          phase_r   <= phase_nxt;
          cnt_r     <= cnt_nxt;
          pause_r   <= pause_nxt;
          strings_r <= strings_nxt;
          low_r     <= low_nxt;
        end
      end
    end
  end

endmodule

@@ rtl/core/tzxdf_queue.sv @@
`timescale 1ns / 1ps
module tzxdf_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  tzxdf_pkg::res_t    push_data,
  output logic               push_ready,
  output logic               pop_valid,
  output tzxdf_pkg::res_t    pop_data,
  input  logic               pop_ready
);
  import tzxdf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CNT_FULL);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/tzxdf_back.sv @@
`timescale 1ns / 1ps
module tzxdf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  tzxdf_pkg::res_t    pop_data,
  output logic               pop_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_data,
  output logic [1:0]         out_kind,
  output logic               out_last
);
  import tzxdf_pkg::*;

  logic        valid_r;
  logic [7:0]  data_r;
  logic [15:0] len_r;
  logic [6:0]  frames_r;
  logic [1:0]  kind_r;
  logic        last_r;
  logic [29:0] prod;
  logic [11:0] quot;
  logic [6:0]  frames_nxt;

  // ms to frames: (ms >> 2) * ceil(2^18 / 5) >> 18, exact for 14-bit inputs
  assign prod       = 30'(pop_data.pause_ms[15:2]) * 30'(RECIP_5);
  assign quot       = prod[29:RECIP_SHIFT];
  assign frames_nxt = (pop_data.pause_ms >= PAUSE_CAP_MS) ? FRAMES_MAX : quot[6:0];

  assign pop_ready = !valid_r | out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop_ready) begin
      valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) begin
      data_r   <= pop_data.data;
      len_r    <= pop_data.len;
      frames_r <= frames_nxt;
      kind_r   <= pop_data.ev;
      last_r   <= pop_data.last;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = {1'b0, frames_r, len_r, data_r};
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule

@@ rtl/core/tzxdf_checker.sv @@
`timescale 1ns / 1ps
`include "tzx_tape_block_deframer_unit_macros.svh"
module tzxdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import tzxdf_pkg::*;

  // stalled result holds
  `TZXDF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // only payload bytes close a block
  `TZXDF_ASSERT_NOW(a_last_payload, out_tvalid && out_tlast, out_tuser == EV_PAYLOAD, "last flag on non-payload result")

  // error results carry no length or pause
  `TZXDF_ASSERT_NOW(a_err_fields, out_tvalid && (out_tuser == EV_BAD_SIG || out_tuser == EV_BAD_ID), out_tdata[30:8] == 23'h0, "error result with length or pause")

  // pause capped, pad bit clear
  `TZXDF_ASSERT_NOW(a_frames_cap, out_tvalid, out_tdata[30:24] <= FRAMES_MAX && !out_tdata[31], "pause frames above cap")

endmodule

bind tzx_tape_block_deframer_unit tzxdf_checker u_checker (.*);
